// ===== hw/rtl/dq_pkg.sv =====
// Shared constants, codes and types for the double-ended queue.
// Used by the top level, controller and datapath of the block and by its channel interfaces.
// Depends on nothing.
`timescale 1ns / 1ps

package dq_pkg;

	// Store geometry and derived widths.
	localparam int DEPTH       = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// Fixed field widths of the channels.
	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 11;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd5;
	localparam logic [OP_W-1:0] OP_COUNT      = 3'd6;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // an operation transfer happens this cycle
		logic load_value;  // capture the store read data into the result
	} dq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_read;  // the offered operation reads a held entry
	} dq_stat_t;

endpackage

// ===== hw/rtl/dq_if.sv =====
// Valid/ready channel interfaces for operations and results.
// Depends on dq_pkg for the field widths.
`timescale 1ns / 1ps

interface dq_op_if;
	logic                                valid;
	logic                                ready;
	logic [dq_pkg::OP_W-1:0]             operation;
	logic signed [dq_pkg::DATA_W-1:0]    push_value;

	modport source (output valid, output operation, output push_value, input ready);
	modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface dq_res_if;
	logic                                valid;
	logic                                ready;
	logic [dq_pkg::STATUS_W-1:0]         status;
	logic signed [dq_pkg::DATA_W-1:0]    read_value;
	logic [dq_pkg::OCC_W-1:0]            occupancy;

	modport source (output valid, output status, output read_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input read_value, input occupancy,
		output ready);
endinterface

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended queue of signed values.
// Depends on dq_pkg, dq_if, dq_ctrl and dq_datapath.
//
// A double-ended queue of up to 1024 signed 32-bit values kept in a ring
// over one RAM with a registered read port. Each request transfer carries one
// operation (push or pop at either end, peek at either end, count, clear) and
// yields exactly one result transfer with a status, the popped or peeked value
// and the occupancy after the operation. Pushes, count and clear write their
// result straight into the output register; pops and peeks that find an entry
// wait for the RAM's registered read as well. The result sits in an
// output register, so a new request is taken while the previous result is
// being drained. Clear leaves the RAM untouched. A push to a full queue returns
// the full status and drops the value.
`timescale 1ns / 1ps

module double_ended_queue (
	input  logic            clk,
	input  logic            arst_n,
	dq_op_if.sink           request,
	dq_res_if.source        result
);
	dq_pkg::dq_cmd_t  cmd;
	dq_pkg::dq_stat_t stat;

	// Handshake sequencing.
	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Ring pointers, store and result register.
	dq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (request.operation),
		.push_value(request.push_value),
		.status    (result.status),
		.read_value(result.read_value),
		.occupancy (result.occupancy)
	);

endmodule

// ===== hw/rtl/dq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/dq_datapath.sv =====
// Datapath of the double-ended queue: ring pointers, count, entry store
// and the result register. Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps

module dq_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dq_pkg::dq_cmd_t                    cmd,
	output dq_pkg::dq_stat_t                   stat,
	input  logic [dq_pkg::OP_W-1:0]            operation,
	input  logic signed [dq_pkg::DATA_W-1:0]   push_value,
	output logic [dq_pkg::STATUS_W-1:0]        status,
	output logic signed [dq_pkg::DATA_W-1:0]   read_value,
	output logic [dq_pkg::OCC_W-1:0]           occupancy
);
	logic [dq_pkg::ADDR_W-1:0]      back_q, front_q;
	logic [dq_pkg::CNT_W-1:0]       count_q;
	logic [dq_pkg::ADDR_W-1:0]      back_d, front_d;
	logic [dq_pkg::CNT_W-1:0]       count_d;
	logic [dq_pkg::STATUS_W-1:0]    status_d;
	logic [dq_pkg::STATUS_W-1:0]    status_q;
	logic [dq_pkg::DATA_W-1:0]      value_q;
	logic [dq_pkg::OCC_W-1:0]       occ_q;

	logic [dq_pkg::ADDR_W-1:0]      back_next, back_prev, front_next, front_prev;
	logic                           empty, full, is_read, back_side;
	logic                           ram_we, ram_re;
	logic [dq_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [dq_pkg::VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [63:0]                    in_ext, rd_ext;

	localparam logic [dq_pkg::ADDR_W-1:0] LAST_SLOT = dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1);
	localparam logic [dq_pkg::CNT_W-1:0]  FULL_CNT  = dq_pkg::CNT_W'(dq_pkg::DEPTH);

	// Ring neighbors of both pointers.
	assign back_next  = (back_q == LAST_SLOT) ? '0 : back_q + 1'b1;
	assign back_prev  = (back_q == '0) ? LAST_SLOT : back_q - 1'b1;
	assign front_next = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign front_prev = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	assign is_read = (operation == dq_pkg::OP_POP_BACK) || (operation == dq_pkg::OP_POP_FRONT)
		|| (operation == dq_pkg::OP_PEEK_BACK) || (operation == dq_pkg::OP_PEEK_FRONT);
	assign back_side = (operation == dq_pkg::OP_POP_BACK) || (operation == dq_pkg::OP_PEEK_BACK);

	assign stat.needs_read = is_read && !empty;

	// Next pointer, count and status for the offered operation.
	always_comb begin
		back_d   = back_q;
		front_d  = front_q;
		count_d  = count_q;
		status_d = dq_pkg::ST_OK;
		ram_we   = 1'b0;
		unique case (operation)
			dq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					ram_we  = 1'b1;
					back_d  = back_next;
					count_d = count_q + 1'b1;
				end
			end
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					ram_we  = 1'b1;
					front_d = front_prev;
					count_d = count_q + 1'b1;
				end
			end
			dq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					back_d  = back_prev;
					count_d = count_q - 1'b1;
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					front_d = front_next;
					count_d = count_q - 1'b1;
				end
			end
			dq_pkg::OP_PEEK_BACK, dq_pkg::OP_PEEK_FRONT: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end
			end
			dq_pkg::OP_COUNT: begin
			end
			dq_pkg::OP_CLEAR: begin
				back_d  = '0;
				front_d = '0;
				count_d = '0;
			end
		endcase
	end

	// Store access: the push value is sign-extended, then kept to the store width.
	assign in_ext    = 64'(push_value);
	assign ram_wdata = in_ext[dq_pkg::VALUE_WIDTH-1:0];
	assign ram_waddr = (operation == dq_pkg::OP_PUSH_BACK) ? back_q : front_prev;
	assign ram_raddr = back_side ? back_prev : front_q;
	assign ram_re    = cmd.accept && stat.needs_read;

	dq_ram #(
		.WIDTH(dq_pkg::VALUE_WIDTH),
		.DEPTH(dq_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept && ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_ext = 64'($signed(ram_rdata));

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_q  <= '0;
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			back_q  <= back_d;
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	// Result register: status and count at the transfer, value from the store later.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= status_d;
			occ_q    <= dq_pkg::OCC_W'(count_d);
			value_q  <= '0;
		end else if (cmd.load_value) begin
			value_q  <= rd_ext[dq_pkg::DATA_W-1:0];
		end
	end

	assign status     = status_q;
	assign read_value = $signed(value_q);
	assign occupancy  = occ_q;

	// The count never exceeds the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count exceeds depth");

	// A push to a full queue leaves the pointers and count unchanged.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && full && ((operation == dq_pkg::OP_PUSH_BACK)
			|| (operation == dq_pkg::OP_PUSH_FRONT))
		|=> status_q == dq_pkg::ST_FULL && $stable(count_q) && $stable(back_q)
			&& $stable(front_q))
		else $error("push to full queue changed state");

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
// Controller of the double-ended queue: sequences operation transfers,
// store reads and the result handshake. Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dq_pkg::dq_stat_t stat,
	output dq_pkg::dq_cmd_t  cmd
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_WAIT = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	// A new operation is taken when no store read is pending and the result register is empty or drains now.
	assign out_free       = !out_valid_q || out_ready;
	assign in_ready       = (state_q == S_IDLE) && out_free;
	assign cmd.accept     = in_valid && in_ready;
	assign cmd.load_value = (state_q == S_WAIT);
	assign out_valid      = out_valid_q;

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						if (stat.needs_read) begin
							state_q     <= S_WAIT;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_WAIT: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A transfer that reads the store enters the wait state for the read data, with no result valid.
	a_read_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && stat.needs_read |=> state_q == S_WAIT && !out_valid_q)
		else $error("store read did not enter wait state");

	// The wait state always completes with a valid result.
	a_wait_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |=> state_q == S_IDLE && out_valid_q)
		else $error("wait state did not deliver a result");

	// A result that is not taken stays valid.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && !$past(cmd.accept))
		else $error("pending result was lost");

endmodule

// ===== sim/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue (double_ended_queue).
// Depends on dq_pkg, the dq_op_if and dq_res_if channel interfaces, and the RTL.
// It predicts every result in order and checks each field against the block.
`timescale 1ns / 1ps

module double_ended_queue_tb;
	import dq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] read_value;
		logic [OCC_W-1:0]         occupancy;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dq_op_if  request_ch ();
	dq_res_if result_ch ();

	double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch)
	);

	// Mirror of the ring contents, its two pointers and the entry count.
	logic signed [VALUE_WIDTH-1:0] ring_slots [DEPTH];
	logic [ADDR_W-1:0]             back_ptr = '0;
	logic [ADDR_W-1:0]             front_ptr = '0;
	logic [CNT_W-1:0]              held_count = '0;

	deque_result_t pending_results [$];
	int            mismatch_count = 0;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	logic          hold_active = 1'b0;
	event          hold_off_begin;
	longint        cycle_count = 0;

	always #5 clk = ~clk;

	function automatic logic [ADDR_W-1:0] ring_fwd(input logic [ADDR_W-1:0] p);
		return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] ring_back(input logic [ADDR_W-1:0] p);
		return (p == '0) ? ADDR_W'(DEPTH - 1) : p - 1'b1;
	endfunction

	// Apply one operation to the mirrored queue and return the result it must give.
	function automatic deque_result_t predict_deque_result(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] value);
		deque_result_t    r;
		logic [ADDR_W-1:0] slot;
		r.status = ST_OK;
		r.read_value = '0;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (held_count >= CNT_W'(DEPTH)) begin
					r.status = ST_FULL;
				end else if (op == OP_PUSH_BACK) begin
					ring_slots[back_ptr] = VALUE_WIDTH'(value);
					back_ptr = ring_fwd(back_ptr);
					held_count = held_count + 1'b1;
				end else begin
					front_ptr = ring_back(front_ptr);
					ring_slots[front_ptr] = VALUE_WIDTH'(value);
					held_count = held_count + 1'b1;
				end
			end
			OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
				if (held_count == '0) begin
					r.status = ST_EMPTY;
				end else begin
					slot = (op == OP_POP_BACK || op == OP_PEEK_BACK) ? ring_back(back_ptr)
						: front_ptr;
					r.read_value = DATA_W'(ring_slots[slot]);
					if (op == OP_POP_BACK) begin
						back_ptr = slot;
						held_count = held_count - 1'b1;
					end else if (op == OP_POP_FRONT) begin
						front_ptr = ring_fwd(front_ptr);
						held_count = held_count - 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				back_ptr = '0;
				front_ptr = '0;
				held_count = '0;
			end
			default: begin
			end
		endcase
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	// Compare one result transfer against the oldest outstanding prediction.
	function automatic void check_result(input logic [STATUS_W-1:0] status,
			input logic signed [DATA_W-1:0] read_value, input logic [OCC_W-1:0] occupancy);
		deque_result_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no operation outstanding");
			mismatch_count++;
			return;
		end
		want = pending_results[0];
		pending_results.delete(0);
		if (status !== want.status) begin
			$error("status mismatch: expected %0d, got %0d", want.status, status);
			mismatch_count++;
		end
		if (read_value !== want.read_value) begin
			$error("read_value mismatch: expected %0d, got %0d", want.read_value, read_value);
			mismatch_count++;
		end
		if (occupancy !== want.occupancy) begin
			$error("occupancy mismatch: expected %0d, got %0d", want.occupancy, occupancy);
			mismatch_count++;
		end
	endfunction

	// Results are checked before the same edge's request is predicted, since a
	// result always belongs to an earlier operation.
	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			check_result(result_ch.status, result_ch.read_value, result_ch.occupancy);
		end
		if (request_ch.valid === 1'b1 && request_ch.ready === 1'b1) begin
			pending_results.insert(pending_results.size(),
				predict_deque_result(request_ch.operation, request_ch.push_value));
		end
	end

	// Result side: random stalls, or held low for the whole hold-off stretch.
	always @(posedge clk) begin
		result_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, timed here so the sender keeps offering meanwhile.
	initial begin
		forever begin
			@(hold_off_begin);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one operation, with random idle cycles first, and wait for its transfer.
	task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.operation <= op;
		request_ch.push_value <= value;
		@(posedge clk);
		while (request_ch.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Mostly random values, with the extremes and the all-zero and all-one words mixed in.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return {1'b0, {(DATA_W - 1){1'b1}}};
			3: return {1'b1, {(DATA_W - 1){1'b0}}};
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Pushes outweigh pops so the queue grows between the occasional clears.
	function automatic logic [OP_W-1:0] pick_op();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 30) return OP_PUSH_BACK;
		if (roll < 55) return OP_PUSH_FRONT;
		if (roll < 67) return OP_POP_BACK;
		if (roll < 79) return OP_POP_FRONT;
		if (roll < 85) return OP_PEEK_BACK;
		if (roll < 91) return OP_PEEK_FRONT;
		if (roll < 97) return OP_COUNT;
		return OP_CLEAR;
	endfunction

	// Empty errors, extreme values at both ends, pointer wrap at the front, and clear.
	task automatic test_ends_and_empty();
		send_op(OP_POP_BACK, pick_value());
		send_op(OP_POP_FRONT, pick_value());
		send_op(OP_PEEK_BACK, pick_value());
		send_op(OP_PEEK_FRONT, pick_value());
		send_op(OP_COUNT, pick_value());
		send_op(OP_PUSH_BACK, {1'b0, {(DATA_W - 1){1'b1}}});
		send_op(OP_PUSH_FRONT, {1'b1, {(DATA_W - 1){1'b0}}});
		send_op(OP_PUSH_BACK, '1);
		send_op(OP_PUSH_FRONT, '0);
		send_op(OP_PEEK_BACK, pick_value());
		send_op(OP_PEEK_FRONT, pick_value());
		send_op(OP_COUNT, pick_value());
		send_op(OP_POP_FRONT, pick_value());
		send_op(OP_POP_BACK, pick_value());
		send_op(OP_POP_FRONT, pick_value());
		send_op(OP_POP_BACK, pick_value());
		send_op(OP_PEEK_BACK, pick_value());
		send_op(OP_PUSH_FRONT, pick_value());
		send_op(OP_PUSH_BACK, pick_value());
		send_op(OP_CLEAR, pick_value());
		send_op(OP_COUNT, pick_value());
		send_op(OP_PEEK_FRONT, pick_value());
		send_op(OP_PUSH_BACK, pick_value());
		send_op(OP_POP_FRONT, pick_value());
	endtask

	// Both pointers cross the last slot in each direction, starting from a clear ring.
	task automatic test_ring_wrap();
		send_op(OP_CLEAR, pick_value());
		send_op(OP_PUSH_FRONT, pick_value());
		send_op(OP_POP_BACK, pick_value());
		send_op(OP_PUSH_BACK, pick_value());
		send_op(OP_PUSH_BACK, pick_value());
		send_op(OP_PEEK_BACK, pick_value());
		send_op(OP_PEEK_FRONT, pick_value());
		send_op(OP_POP_FRONT, pick_value());
		send_op(OP_POP_FRONT, pick_value());
		send_op(OP_POP_FRONT, pick_value());
		repeat (4) send_op(OP_PUSH_FRONT, pick_value());
		repeat (4) send_op(OP_POP_BACK, pick_value());
		send_op(OP_CLEAR, pick_value());
	endtask

	// The receiver stops for a long stretch while operations keep coming.
	task automatic test_backpressure();
		send_idle_pct <= 0;
		recv_stall_pct <= 0;
		-> hold_off_begin;
		repeat (40) send_op(pick_op(), pick_value());
	endtask

	task automatic test_random_mix(input int n_items, input int unsigned send_pct,
			input int unsigned recv_pct);
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
		repeat (n_items) send_op(pick_op(), pick_value());
	endtask

	initial begin
		request_ch.valid = 1'b0;
		request_ch.operation = OP_COUNT;
		request_ch.push_value = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ends_and_empty();
		test_ring_wrap();
		test_backpressure();
		test_random_mix(118, 0, 0);
		test_random_mix(118, 53, 0);
		test_random_mix(118, 0, 53);
		test_random_mix(118, 10, 10);

		request_ch.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== double_ended_queue.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_if.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_datapath.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue.sv
sim/double_ended_queue_tb.sv
